@@ rtl/six_part_music_sequencer_unit_defines.svh @@
// assertion macros for the six-part music sequencer
// used by six_part_music_sequencer_unit.sv; clock clk, reset rst_n
`ifndef SIX_PART_MUSIC_SEQUENCER_UNIT_DEFINES_SVH
`define SIX_PART_MUSIC_SEQUENCER_UNIT_DEFINES_SVH

// condition that holds at every edge out of reset
`define SPMS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked at every edge out of reset
`define SPMS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/spms_pkg.sv @@
// shared types and constants for the six-part music sequencer
// no dependencies
`timescale 1ns / 1ps

package spms_pkg;

  localparam int PART_FW  = 3;
  localparam int STEP_W   = 11;
  localparam logic [STEP_W-1:0] CMD_BUDGET = 11'd1024;

  typedef enum logic [2:0] {
    EV_KEY_OFF = 3'd0,
    EV_KEY_ON  = 3'd1,
    EV_TONE    = 3'd2,
    EV_REG     = 3'd3,
    EV_OVERRUN = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PLAY  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_t;

  localparam logic [7:0] CMD_REG  = 8'd225;
  localparam logic [7:0] CMD_VOL  = 8'd226;
  localparam logic [7:0] CMD_DLEN = 8'd227;
  localparam logic [7:0] CMD_TONE = 8'd228;
  localparam logic [7:0] CMD_SYNC = 8'd254;
  localparam logic [7:0] CMD_LOOP = 8'd255;

  localparam int CFG_STARTS = 6;
  localparam logic [2:0] CFG_LOAD_BASE = 3'd6;
  localparam logic [15:0] LOAD_BASE_RST = 16'h1000;
  localparam logic [7:0] DLEN_RST  = 8'd5;
  localparam logic [7:0] VOL_RST   = 8'd15;
  localparam logic [7:0] VOL_EMPTY = 8'd255;
  localparam logic [7:0] VOL_PLAY  = 8'd0;

  typedef struct packed {
    ev_t                event_res;
    logic [PART_FW-1:0] part;
    logic [7:0]         value;
    logic [7:0]         extra;
  } res_t;

  typedef struct packed {
    logic put;
    logic fin;
  } outq_ctl_t;

  typedef struct packed {
    logic [15:0] ptr;
    logic [15:0] loop;
    logic [7:0]  dur;
    logic [7:0]  dlen;
    logic [7:0]  vol;
    mode_t       mode;
  } part_rec_t;

endpackage

@@ rtl/six_part_music_sequencer_unit.sv @@
// six-part music sequencer: music byte memory, part record memory and command sequencer
// depends on spms_pkg, spms_outq and six_part_music_sequencer_unit_defines.svh
`timescale 1ns / 1ps
`include "six_part_music_sequencer_unit_defines.svh"

// a write word is stored into music memory; a stop puts one word per part, a start loads
// and rewrites each part record; a tick visits each part and runs commands (loop, sync,
// volume, tone, note or register write) for parts whose duration ran out, then a sync release pass
// one item at a time; results leave through a pending word and an output register
// reset is synchronous active low; afterwards a clearing pass writes the part records
// before the first word is taken

module six_part_music_sequencer_unit #(
  parameter int PARTS                = 6,
  parameter int MEM_ADDR_BITS        = 16,
  parameter int MAX_RESULTS_PER_ITEM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // kind, address, byte_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // event_res, part, value, extra
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int IW = $clog2(PARTS + 1);
  localparam int RW = $clog2(MAX_RESULTS_PER_ITEM + 1);
  localparam int MA = MEM_ADDR_BITS;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_START_LD, ST_START_GO, ST_STOP,
    ST_T_LD, ST_T_GET, ST_T_NEXT, ST_CMD_A, ST_CMD_B,
    ST_OP1_A, ST_OP1_B, ST_OP2_A, ST_OP2_B, ST_DO,
    ST_NOTE_OFF, ST_NOTE_ON, ST_LEN, ST_LEN_A, ST_LEN_B,
    ST_OVR2, ST_WB, ST_REL_LD, ST_REL_GO, ST_FLUSH
  } state_t;

  // input word fields
  spms_pkg::kind_t kind;
  logic [15:0]     in_addr;
  logic [7:0]      in_byte;
  assign kind    = spms_pkg::kind_t'(in_tdata[1:0]);
  assign in_addr = in_tdata[17:2];
  assign in_byte = in_tdata[25:18];

  // configuration registers
  logic [15:0] cfg_start_r [spms_pkg::CFG_STARTS];
  logic [15:0] load_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spms_pkg::CFG_STARTS; i++) cfg_start_r[i] <= 16'd0;
      load_base_r <= spms_pkg::LOAD_BASE_RST;
    end else if (cfg_we) begin
      if (cfg_index < spms_pkg::CFG_LOAD_BASE) begin
        cfg_start_r[cfg_index] <= cfg_wdata;
      end else if (cfg_index == spms_pkg::CFG_LOAD_BASE) begin
        load_base_r <= cfg_wdata;
      end
    end
  end

  // control and working registers
  state_t              state_r, state_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic [spms_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [RW-1:0]       res_n_r, res_n_nxt;
  logic [IW-1:0]       idle_r, idle_nxt;
  logic [IW-1:0]       rel_r, rel_nxt;
  logic                running_r, running_nxt;
  spms_pkg::part_rec_t w_r, w_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [7:0]          r_r, r_nxt;
  logic [7:0]          d_r, d_nxt;

  // memories
  logic [7:0]          mm [2**MA];
  logic [7:0]          mm_q;
  logic                mm_we;
  spms_pkg::part_rec_t rec_mem [PARTS];
  spms_pkg::part_rec_t rec_q;
  logic                rec_we;
  spms_pkg::part_rec_t rec_wd;

  always_ff @(posedge clk) begin
    if (mm_we) begin
      mm[in_addr[MA-1:0]] <= in_byte;
    end
    mm_q <= mm[w_r.ptr[MA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[p_r] <= rec_wd;
    end
    rec_q <= rec_mem[p_r];
  end

  // result path
  spms_pkg::outq_ctl_t oq_ctl;
  spms_pkg::res_t      oq_res;
  logic                can_put;
  logic                fin_done;

  spms_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (oq_ctl),
    .res        (oq_res),
    .can_put    (can_put),
    .fin_done   (fin_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  logic        last_part;
  logic        over;
  logic [15:0] start_addr;
  logic        rel_one;
  logic [IW-1:0] rel_tot;

  assign last_part  = (p_r == PW'(PARTS - 1));
  assign over       = (res_n_r >= RW'(MAX_RESULTS_PER_ITEM - 1));
  assign start_addr = (32'(p_r) < spms_pkg::CFG_STARTS) ? cfg_start_r[3'(p_r)] : 16'd0;
  assign rel_one    = (rec_q.mode != spms_pkg::MODE_EMPTY);
  assign rel_tot    = rel_r + IW'(rel_one);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    p_nxt       = p_r;
    steps_nxt   = steps_r;
    res_n_nxt   = res_n_r;
    idle_nxt    = idle_r;
    rel_nxt     = rel_r;
    running_nxt = running_r;
    w_nxt       = w_r;
    cmd_nxt     = cmd_r;
    r_nxt       = r_r;
    d_nxt       = d_r;
    mm_we       = 1'b0;
    rec_we      = 1'b0;
    rec_wd      = w_r;
    oq_ctl      = '{put: 1'b0, fin: 1'b0};
    oq_res      = '{event_res: spms_pkg::EV_KEY_OFF, part: 3'(p_r), value: 8'd0, extra: 8'd0};

    case (state_r)
      ST_INIT: begin
        // clearing pass over the part records
        rec_we = 1'b1;
        rec_wd = '{ptr: 16'd0, loop: 16'd0, dur: 8'd1, dlen: spms_pkg::DLEN_RST,
                   vol: spms_pkg::VOL_RST, mode: spms_pkg::MODE_PLAY};
        if (last_part) begin
          p_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          p_nxt = p_r + PW'(1);
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          p_nxt = '0;
          case (kind)
            spms_pkg::KIND_WRITE: mm_we = 1'b1;
            spms_pkg::KIND_START: begin
              idle_nxt  = '0;
              state_nxt = ST_START_LD;
            end
            spms_pkg::KIND_TICK: begin
              if (running_r) begin
                steps_nxt = '0;
                res_n_nxt = '0;
                state_nxt = ST_T_LD;
              end
            end
            default: begin
              running_nxt = 1'b0;
              state_nxt   = ST_STOP;
            end
          endcase
        end
      end

      ST_START_LD: state_nxt = ST_START_GO;

      ST_START_GO: begin
        if (can_put) begin
          // default length is kept over a start
          rec_wd      = rec_q;
          rec_wd.dur  = 8'd1;
          rec_wd.loop = start_addr - load_base_r;
          rec_wd.ptr  = start_addr - load_base_r;
          if (start_addr == 16'd0) begin
            rec_wd.mode = spms_pkg::MODE_EMPTY;
            rec_wd.vol  = spms_pkg::VOL_EMPTY;
            idle_nxt    = idle_r + IW'(1);
          end else begin
            rec_wd.mode = spms_pkg::MODE_PLAY;
            rec_wd.vol  = spms_pkg::VOL_PLAY;
          end
          rec_we           = 1'b1;
          oq_ctl.put       = 1'b1;
          oq_res.event_res = spms_pkg::EV_TONE;
          if (last_part) begin
            running_nxt = 1'b1;
            state_nxt   = ST_FLUSH;
          end else begin
            p_nxt     = p_r + PW'(1);
            state_nxt = ST_START_LD;
          end
        end
      end

      ST_STOP: begin
        if (can_put) begin
          oq_ctl.put = 1'b1;
          if (last_part) begin
            state_nxt = ST_FLUSH;
          end else begin
            p_nxt = p_r + PW'(1);
          end
        end
      end

      ST_T_LD: state_nxt = ST_T_GET;

      ST_T_GET: begin
        w_nxt = rec_q;
        if (rec_q.mode != spms_pkg::MODE_PLAY) begin
          state_nxt = ST_T_NEXT;
        end else begin
          w_nxt.dur = rec_q.dur - 8'd1;
          state_nxt = (w_nxt.dur == 8'd0) ? ST_CMD_A : ST_T_NEXT;
        end
      end

      ST_T_NEXT: begin
        rec_we = 1'b1;
        if (last_part) begin
          p_nxt = '0;
          if (idle_r == IW'(PARTS)) begin
            rel_nxt   = '0;
            state_nxt = ST_REL_LD;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end else begin
          p_nxt     = p_r + PW'(1);
          state_nxt = ST_T_LD;
        end
      end

      ST_CMD_A: begin
        if (steps_r >= spms_pkg::CMD_BUDGET) begin
          // endless commands: an overrun word, then a second one if budget allowed
          if (can_put) begin
            oq_ctl.put       = 1'b1;
            oq_res.event_res = spms_pkg::EV_OVERRUN;
            if (over) begin
              running_nxt = 1'b0;
              state_nxt   = ST_WB;
            end else begin
              res_n_nxt = res_n_r + RW'(1);
              state_nxt = ST_OVR2;
            end
          end
        end else begin
          steps_nxt = steps_r + spms_pkg::STEP_W'(1);
          state_nxt = ST_CMD_B;
        end
      end

      ST_CMD_B: begin
        cmd_nxt = mm_q;
        case (mm_q)
          spms_pkg::CMD_VOL, spms_pkg::CMD_DLEN, spms_pkg::CMD_TONE,
          spms_pkg::CMD_REG: begin
            w_nxt.ptr = w_r.ptr - 16'd1;
            state_nxt = ST_OP1_A;
          end
          spms_pkg::CMD_LOOP: begin
            w_nxt.ptr = w_r.loop;
            state_nxt = ST_CMD_A;
          end
          spms_pkg::CMD_SYNC: begin
            w_nxt.mode = spms_pkg::MODE_WAIT;
            w_nxt.ptr  = w_r.ptr - 16'd1;
            idle_nxt   = idle_r + IW'(1);
            state_nxt  = ST_T_NEXT;
          end
          default: state_nxt = ST_NOTE_OFF;
        endcase
      end

      ST_OP1_A: state_nxt = ST_OP1_B;

      ST_OP1_B: begin
        r_nxt = mm_q;
        case (cmd_r)
          spms_pkg::CMD_VOL: begin
            w_nxt.vol = mm_q;
            w_nxt.ptr = w_r.ptr - 16'd1;
            state_nxt = ST_CMD_A;
          end
          spms_pkg::CMD_DLEN: begin
            w_nxt.dlen = mm_q;
            w_nxt.ptr  = w_r.ptr - 16'd1;
            state_nxt  = ST_CMD_A;
          end
          spms_pkg::CMD_REG: begin
            w_nxt.ptr = w_r.ptr - 16'd1;
            state_nxt = ST_OP2_A;
          end
          default: state_nxt = ST_DO;
        endcase
      end

      ST_OP2_A: state_nxt = ST_OP2_B;

      ST_OP2_B: begin
        d_nxt     = mm_q;
        state_nxt = ST_DO;
      end

      ST_DO: begin
        if (can_put) begin
          oq_ctl.put = 1'b1;
          if (over) begin
            oq_res.event_res = spms_pkg::EV_OVERRUN;
            running_nxt      = 1'b0;
            state_nxt        = ST_WB;
          end else begin
            oq_res.value = r_r;
            if (cmd_r == spms_pkg::CMD_REG) begin
              oq_res.event_res = spms_pkg::EV_REG;
              oq_res.extra     = d_r;
            end else begin
              oq_res.event_res = spms_pkg::EV_TONE;
            end
            res_n_nxt = res_n_r + RW'(1);
            w_nxt.ptr = w_r.ptr - 16'd1;
            state_nxt = ST_CMD_A;
          end
        end
      end

      ST_NOTE_OFF: begin
        if (can_put) begin
          oq_ctl.put = 1'b1;
          if (over) begin
            oq_res.event_res = spms_pkg::EV_OVERRUN;
            running_nxt      = 1'b0;
            state_nxt        = ST_WB;
          end else begin
            res_n_nxt = res_n_r + RW'(1);
            state_nxt = (cmd_r[6:0] != 7'd0) ? ST_NOTE_ON : ST_LEN;
          end
        end
      end

      ST_NOTE_ON: begin
        if (can_put) begin
          oq_ctl.put = 1'b1;
          if (over) begin
            oq_res.event_res = spms_pkg::EV_OVERRUN;
            running_nxt      = 1'b0;
            state_nxt        = ST_WB;
          end else begin
            oq_res.event_res = spms_pkg::EV_KEY_ON;
            oq_res.value     = {1'b0, cmd_r[6:0]} - 8'd1;
            res_n_nxt        = res_n_r + RW'(1);
            state_nxt        = ST_LEN;
          end
        end
      end

      ST_LEN: begin
        w_nxt.ptr = w_r.ptr - 16'd1;
        if (cmd_r[7]) begin
          w_nxt.dur = w_r.dlen;
          state_nxt = ST_T_NEXT;
        end else begin
          state_nxt = ST_LEN_A;
        end
      end

      ST_LEN_A: state_nxt = ST_LEN_B;

      ST_LEN_B: begin
        w_nxt.dur = mm_q;
        w_nxt.ptr = w_r.ptr - 16'd1;
        state_nxt = ST_T_NEXT;
      end

      ST_OVR2: begin
        if (can_put) begin
          oq_ctl.put       = 1'b1;
          oq_res.event_res = spms_pkg::EV_OVERRUN;
          running_nxt      = 1'b0;
          state_nxt        = ST_WB;
        end
      end

      ST_WB: begin
        // keep what the part changed before the overrun
        rec_we    = 1'b1;
        state_nxt = ST_FLUSH;
      end

      ST_REL_LD: state_nxt = ST_REL_GO;

      ST_REL_GO: begin
        rec_wd = rec_q;
        if (rel_one) begin
          rec_wd.mode = spms_pkg::MODE_PLAY;
          rec_wd.dur  = 8'd1;
        end
        rec_we  = 1'b1;
        rel_nxt = rel_tot;
        if (last_part) begin
          p_nxt     = '0;
          idle_nxt  = IW'(PARTS) - rel_tot;
          state_nxt = (rel_tot == '0) ? ST_FLUSH : ST_T_LD;
        end else begin
          p_nxt     = p_r + PW'(1);
          state_nxt = ST_REL_LD;
        end
      end

      ST_FLUSH: begin
        oq_ctl.fin = 1'b1;
        if (fin_done) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      p_r       <= '0;
      steps_r   <= '0;
      res_n_r   <= '0;
      idle_r    <= '0;
      rel_r     <= '0;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_r       <= p_nxt;
      steps_r   <= steps_nxt;
      res_n_r   <= res_n_nxt;
      idle_r    <= idle_nxt;
      rel_r     <= rel_nxt;
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    cmd_r <= cmd_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
  end

  // checks
  `SPMS_CHECK(a_idle_bound, idle_r <= IW'(PARTS), "idle part count beyond part count")
  `SPMS_CHECK(a_budget_bound, res_n_r <= RW'(MAX_RESULTS_PER_ITEM - 1), "result count over budget")
  `SPMS_IMPLY(a_tick_clean, state_r == ST_T_LD && $past(state_r) == ST_IDLE, res_n_r == '0 && steps_r == '0, "tick began with stale counters")
  `SPMS_IMPLY(a_no_rec_write_idle, state_r == ST_IDLE, !rec_we, "part record written while idle")

endmodule

@@ rtl/spms_outq.sv @@
// result buffer: one pending word plus the output register
// the pending word lets the last flag be set once the item is finished; uses spms_pkg
`timescale 1ns / 1ps

module spms_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  spms_pkg::outq_ctl_t ctl,
  input  spms_pkg::res_t      res,
  output logic                can_put,
  output logic                fin_done,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // event_res, part, value, extra
  output logic                out_tlast
);

  logic           pend_v_r;
  spms_pkg::res_t pend_r;
  logic           oval_r;
  spms_pkg::res_t ores_r;
  logic           olast_r;
  logic           out_free;

  assign out_free = !oval_r || out_tready;
  assign can_put  = !pend_v_r || out_free;
  assign fin_done = !pend_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      if (out_tready) begin
        oval_r <= 1'b0;
      end
      if (ctl.put && can_put) begin
        pend_r   <= res;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          ores_r  <= pend_r;
          olast_r <= 1'b0;
          oval_r  <= 1'b1;
        end
      end else if (ctl.fin && pend_v_r && out_free) begin
        ores_r   <= pend_r;
        olast_r  <= 1'b1;
        oval_r   <= 1'b1;
        pend_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {2'b00, ores_r.extra, ores_r.value, ores_r.part, ores_r.event_res};
  assign out_tlast  = olast_r;

endmodule
